FILE: rtl/core/ioi_pkg.sv
package ioi_pkg;

  localparam int MAIN_DEPTH = 1024;
  localparam int LONG_DEPTH = 16;
  localparam int MAX_HITS   = 64;

  localparam int POS_W   = 32;
  localparam int GENE_W  = 20;
  localparam int SCAN_W  = 11;
  localparam int MAIN_AW = $clog2(MAIN_DEPTH);
  localparam int CNT_W   = $clog2(MAIN_DEPTH + 1);
  localparam int LONG_AW = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
  localparam int LCNT_W  = $clog2(LONG_DEPTH + 1);
  localparam int HIT_W   = $clog2(MAX_HITS + 1);

  localparam logic [POS_W-1:0] LONG_LEN_RESET = 32'd65536;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [POS_W-1:0]  range_start;
    logic [POS_W-1:0]  range_end;
    logic [GENE_W-1:0] gene_tag;
    logic              final_insert;
  } in_item_t;

  typedef struct packed {
    logic [GENE_W-1:0] hit_gene;
    logic              hit_valid;
    logic              run_last;
    logic              truncated;
    logic [SCAN_W-1:0] scanned_count;
    logic              store_full;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
    logic [GENE_W-1:0] gene;
    logic [POS_W-1:0]  pmax;
  } main_ent_t;

endpackage

FILE: rtl/core/interval_overlap_index_top.sv
// Interval overlap index. Insert items (operation 0) load half-open intervals
// [range_start, range_end) with a gene tag; each insert answers one item at
// once, but an insert flagged final_insert then builds the table: an
// insertion sort of the main store in its memory (each key is read, larger
// entries before it are compared and shifted up one at a time, then the key
// is placed) followed by a prefix-maximum pass that reads and rewrites each
// entry. A query (operation 1) builds first if needed, then scans the long
// list entry by entry, binary-searches the main store, and walks backward one
// examined entry at a time, so its time grows with the number of entries
// examined. Matches stream out in order, up to MAX_HITS of them; the last
// item of a query carries the truncation flag and scan count.
// Only one item is worked on at a time: in_stall stays high until the block
// is back in its idle state and the output register can take a new item.
// The register long_len may be written through cfg_we/cfg_wdata while idle.
module interval_overlap_index_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ioi_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ioi_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);
  import ioi_pkg::*;

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_SORT_NEXT  = 4'd1;
  localparam logic [3:0] ST_SORT_KEY   = 4'd2;
  localparam logic [3:0] ST_SORT_CMP   = 4'd3;
  localparam logic [3:0] ST_SORT_PLACE = 4'd4;
  localparam logic [3:0] ST_PFX_RD     = 4'd5;
  localparam logic [3:0] ST_PFX_WR     = 4'd6;
  localparam logic [3:0] ST_QCHK       = 4'd7;
  localparam logic [3:0] ST_LSCAN      = 4'd8;
  localparam logic [3:0] ST_BS_RD      = 4'd9;
  localparam logic [3:0] ST_BS_CMP     = 4'd10;
  localparam logic [3:0] ST_WK_RD      = 4'd11;
  localparam logic [3:0] ST_WK_CMP     = 4'd12;
  localparam logic [3:0] ST_FIN        = 4'd13;

  // Main store: one memory holding sorted entries and their running max end.
  main_ent_t main_mem [MAIN_DEPTH];
  main_ent_t mem_rdata_r;
  logic                mem_we, mem_re;
  logic [MAIN_AW-1:0]  mem_waddr, mem_raddr;
  main_ent_t           mem_wdata;

  // Long list: small register file read only at the scan index.
  logic [POS_W-1:0]  long_start [LONG_DEPTH];
  logic [POS_W-1:0]  long_end   [LONG_DEPTH];
  logic [GENE_W-1:0] long_gene  [LONG_DEPTH];
  logic              long_we;
  logic [LONG_AW-1:0] long_waddr;

  logic [3:0]        state_r, state_nxt;
  logic [POS_W-1:0]  long_len_r;
  logic [CNT_W-1:0]  main_count_r, main_count_nxt;
  logic [LCNT_W-1:0] long_count_r, long_count_nxt;
  logic              built_r, built_nxt;
  logic              bq_r, bq_nxt;
  logic [POS_W-1:0]  qs_r, qs_nxt, qe_r, qe_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [LCNT_W-1:0] li_r, li_nxt;
  main_ent_t         key_r, key_nxt;
  logic [POS_W-1:0]  run_r, run_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [HIT_W-1:0]  nhits_r, nhits_nxt;
  logic              trunc_r, trunc_nxt;
  logic              pend_r, pend_nxt;
  logic [GENE_W-1:0] pgene_r, pgene_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              can_push, push_en, accept;
  out_item_t         push_item;
  logic              hit, hit_room, hit_block;
  logic [GENE_W-1:0] hit_gene;
  logic [CNT_W-1:0]  mc_eff;
  logic [LCNT_W-1:0] lc_eff;
  logic              is_long;
  logic [POS_W-1:0]  ins_len;
  logic [CNT_W:0]    mid_sum;
  logic [LONG_AW-1:0] lrd;

  assign can_push  = !out_valid_r || !out_stall;
  assign in_stall  = !(state_r == ST_IDLE && can_push);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign lrd       = li_r[LONG_AW-1:0];
  assign ins_len   = in_item.range_end - in_item.range_start;
  assign is_long   = (in_item.range_end >= in_item.range_start) && (ins_len >= long_len_r);
  assign mc_eff    = built_r ? '0 : main_count_r;
  assign lc_eff    = built_r ? '0 : long_count_r;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      main_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= main_mem[mem_raddr];
    end
    if (long_we) begin
      long_start[long_waddr] <= in_item.range_start;
      long_end[long_waddr]   <= in_item.range_end;
      long_gene[long_waddr]  <= in_item.gene_tag;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    main_count_nxt = main_count_r;
    long_count_nxt = long_count_r;
    built_nxt      = built_r;
    bq_nxt         = bq_r;
    qs_nxt         = qs_r;
    qe_nxt         = qe_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    li_nxt         = li_r;
    key_nxt        = key_r;
    run_nxt        = run_r;
    scan_nxt       = scan_r;
    nhits_nxt      = nhits_r;
    trunc_nxt      = trunc_r;
    pend_nxt       = pend_r;
    pgene_nxt      = pgene_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = '0;
    mem_raddr      = '0;
    mem_wdata      = key_r;
    long_we        = 1'b0;
    long_waddr     = lc_eff[LONG_AW-1:0];
    push_en        = 1'b0;
    push_item      = '0;
    hit            = 1'b0;
    hit_gene       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.operation == OP_INSERT) begin
            main_count_nxt = mc_eff;
            long_count_nxt = lc_eff;
            built_nxt      = 1'b0;
            push_item.run_last = 1'b1;
            if (is_long && lc_eff < LCNT_W'(LONG_DEPTH)) begin
              long_we        = 1'b1;
              long_count_nxt = lc_eff + 1'b1;
            end else if (mc_eff < CNT_W'(MAIN_DEPTH)) begin
              mem_we              = 1'b1;
              mem_waddr           = mc_eff[MAIN_AW-1:0];
              mem_wdata.start_pos = in_item.range_start;
              mem_wdata.end_pos   = in_item.range_end;
              mem_wdata.gene      = in_item.gene_tag;
              mem_wdata.pmax      = '0;
              main_count_nxt      = mc_eff + 1'b1;
            end else begin
              push_item.store_full = 1'b1;
            end
            push_en = 1'b1;
            if (in_item.final_insert) begin
              bq_nxt    = 1'b0;
              i_nxt     = CNT_W'(1);
              state_nxt = ST_SORT_NEXT;
            end
          end else begin
            qs_nxt = in_item.range_start;
            qe_nxt = in_item.range_end;
            if (built_r) begin
              state_nxt = ST_QCHK;
            end else begin
              bq_nxt    = 1'b1;
              i_nxt     = CNT_W'(1);
              state_nxt = ST_SORT_NEXT;
            end
          end
        end
      end
      ST_SORT_NEXT: begin
        if (i_r >= main_count_r) begin
          i_nxt     = '0;
          state_nxt = ST_PFX_RD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = i_r[MAIN_AW-1:0];
          state_nxt = ST_SORT_KEY;
        end
      end
      ST_SORT_KEY: begin
        key_nxt   = mem_rdata_r;
        j_nxt     = i_r;
        mem_re    = 1'b1;
        mem_raddr = MAIN_AW'(i_r - 1'b1);
        state_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[MAIN_AW-1:0];
        if ((mem_rdata_r.start_pos > key_r.start_pos) ||
            (mem_rdata_r.start_pos == key_r.start_pos &&
             mem_rdata_r.end_pos > key_r.end_pos)) begin
          mem_wdata = mem_rdata_r;
          j_nxt     = j_r - 1'b1;
          if (j_r == CNT_W'(1)) begin
            state_nxt = ST_SORT_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = MAIN_AW'(j_r - CNT_W'(2));
          end
        end else begin
          mem_wdata = key_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SORT_NEXT;
        end
      end
      ST_SORT_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = key_r;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_SORT_NEXT;
      end
      ST_PFX_RD: begin
        if (i_r >= main_count_r) begin
          built_nxt = 1'b1;
          state_nxt = bq_r ? ST_QCHK : ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = i_r[MAIN_AW-1:0];
          state_nxt = ST_PFX_WR;
        end
      end
      ST_PFX_WR: begin
        mem_wdata = mem_rdata_r;
        if (i_r == '0 || mem_rdata_r.end_pos > run_r) begin
          run_nxt        = mem_rdata_r.end_pos;
          mem_wdata.pmax = mem_rdata_r.end_pos;
        end else begin
          mem_wdata.pmax = run_r;
        end
        mem_we    = 1'b1;
        mem_waddr = i_r[MAIN_AW-1:0];
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_PFX_RD;
      end
      ST_QCHK: begin
        scan_nxt  = '0;
        nhits_nxt = '0;
        trunc_nxt = 1'b0;
        pend_nxt  = 1'b0;
        li_nxt    = '0;
        if (qe_r <= qs_r) begin
          push_item.run_last = 1'b1;
          if (can_push) begin
            push_en   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_LSCAN;
        end
      end
      ST_LSCAN: begin
        if (li_r >= long_count_r) begin
          lo_nxt    = '0;
          hi_nxt    = main_count_r;
          state_nxt = ST_BS_RD;
        end else begin
          hit      = (long_start[lrd] < qe_r) && (long_end[lrd] > qs_r);
          hit_gene = long_gene[lrd];
          if (!hit_block) begin
            scan_nxt = scan_r + 1'b1;
            li_nxt   = li_r + 1'b1;
          end
        end
      end
      ST_BS_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CNT_W:1];
          mem_re    = 1'b1;
          mem_raddr = mid_sum[MAIN_AW:1];
          state_nxt = ST_BS_CMP;
        end else begin
          i_nxt     = lo_r;
          state_nxt = ST_WK_RD;
        end
      end
      ST_BS_CMP: begin
        if (mem_rdata_r.start_pos < qe_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_BS_RD;
      end
      ST_WK_RD: begin
        if (i_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = MAIN_AW'(i_r - 1'b1);
          state_nxt = ST_WK_CMP;
        end
      end
      ST_WK_CMP: begin
        if (mem_rdata_r.pmax <= qs_r) begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_FIN;
        end else begin
          hit      = mem_rdata_r.end_pos > qs_r;
          hit_gene = mem_rdata_r.gene;
          if (!hit_block) begin
            scan_nxt  = scan_r + 1'b1;
            i_nxt     = i_r - 1'b1;
            state_nxt = ST_WK_RD;
          end
        end
      end
      ST_FIN: begin
        push_item.hit_gene      = pend_r ? pgene_r : '0;
        push_item.hit_valid     = pend_r;
        push_item.run_last      = 1'b1;
        push_item.truncated     = trunc_r;
        push_item.scanned_count = scan_r;
        if (can_push) begin
          push_en   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A new match sends the previously held one out; the newest is held back
    // so that the final item can carry the run_last, truncation and count.
    if (hit && !hit_block) begin
      if (hit_room) begin
        if (pend_r) begin
          push_en             = 1'b1;
          push_item           = '0;
          push_item.hit_gene  = pgene_r;
          push_item.hit_valid = 1'b1;
        end
        pend_nxt  = 1'b1;
        pgene_nxt = hit_gene;
        nhits_nxt = nhits_r + 1'b1;
      end else begin
        trunc_nxt = 1'b1;
      end
    end
  end

  assign hit_room  = nhits_r < HIT_W'(MAX_HITS);
  assign hit_block = hit && hit_room && pend_r && !can_push;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (push_en) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      long_len_r   <= LONG_LEN_RESET;
      main_count_r <= '0;
      long_count_r <= '0;
      built_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      nhits_r      <= '0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        long_len_r <= cfg_wdata;
      end
      main_count_r <= main_count_nxt;
      long_count_r <= long_count_nxt;
      built_r      <= built_nxt;
      out_valid_r  <= out_valid_nxt;
      nhits_r      <= nhits_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bq_r    <= bq_nxt;
    qs_r    <= qs_nxt;
    qe_r    <= qe_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    li_r    <= li_nxt;
    key_r   <= key_nxt;
    run_r   <= run_nxt;
    scan_r  <= scan_nxt;
    trunc_r <= trunc_nxt;
    pgene_r <= pgene_nxt;
    out_r   <= out_nxt;
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_hit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nhits_r <= HIT_W'(MAX_HITS))
    else $error("hit count above cap");
  a_main_cap: assert property (@(posedge clk) disable iff (!rst_n)
    main_count_r <= CNT_W'(MAIN_DEPTH))
    else $error("main count above depth");
  a_final_builds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.operation == OP_INSERT && in_item.final_insert)
      |=> (state_r == ST_SORT_NEXT))
    else $error("final insert did not start build");
`endif

endmodule

FILE: dv/interval_overlap_index_top_test.sv
module interval_overlap_index_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ioi_pkg::*;

  // Clock, reset and the block's ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interval_overlap_index_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the index. The main store is kept in insert order until a
  // build sorts it, exactly as the hardware does.
  logic [POS_W-1:0] shadow_long_len;
  logic [POS_W-1:0] main_lo [MAIN_DEPTH];
  logic [POS_W-1:0] main_hi [MAIN_DEPTH];
  logic [GENE_W-1:0] main_tag [MAIN_DEPTH];
  logic [POS_W-1:0] main_reach [MAIN_DEPTH];
  logic [POS_W-1:0] long_lo [LONG_DEPTH];
  logic [POS_W-1:0] long_hi [LONG_DEPTH];
  logic [GENE_W-1:0] long_tag [LONG_DEPTH];
  int main_fill;
  int long_fill;
  bit is_built;

  out_item_t pending_hits[$];
  int failures = 0;
  int hits_seen = 0;
  int items_sent = 0;
  int queries_sent = 0;
  longint cycle_count = 0;

  // Sender idling: bursts of random length separated by random gaps.
  int burst_left = 0;

  // Stable insertion sort by (start, end), then the running maximum of end.
  task automatic build_index();
    logic [POS_W-1:0] s, e;
    logic [GENE_W-1:0] g;
    logic [POS_W-1:0] reach;
    int j;
    for (int i = 1; i < main_fill; i++) begin
      s = main_lo[i];
      e = main_hi[i];
      g = main_tag[i];
      j = i;
      while (j > 0 && (main_lo[j-1] > s || (main_lo[j-1] == s && main_hi[j-1] > e))) begin
        main_lo[j] = main_lo[j-1];
        main_hi[j] = main_hi[j-1];
        main_tag[j] = main_tag[j-1];
        j--;
      end
      main_lo[j] = s;
      main_hi[j] = e;
      main_tag[j] = g;
    end
    reach = '0;
    for (int i = 0; i < main_fill; i++) begin
      if (i == 0 || main_hi[i] > reach) reach = main_hi[i];
      main_reach[i] = reach;
    end
    is_built = 1'b1;
  endtask

  task automatic add_result(logic [GENE_W-1:0] g, logic v, logic l, logic t,
                            logic [SCAN_W-1:0] n, logic f);
    out_item_t r;
    r.hit_gene = g;
    r.hit_valid = v;
    r.run_last = l;
    r.truncated = t;
    r.scanned_count = n;
    r.store_full = f;
    pending_hits.insert(pending_hits.size(), r);
  endtask

  // Works out the items that one accepted input item produces.
  task automatic predict_overlaps(in_item_t it);
    logic [POS_W-1:0] s, e;
    logic [GENE_W-1:0] found[$];
    bit trunc, full, is_long;
    int scanned, lo, hi, mid, k;
    s = it.range_start;
    e = it.range_end;
    if (it.operation == OP_INSERT) begin
      full = 1'b0;
      is_long = (e >= s) && ((e - s) >= shadow_long_len);
      if (is_built) begin
        main_fill = 0;
        long_fill = 0;
        is_built = 1'b0;
      end
      if (is_long && long_fill < LONG_DEPTH) begin
        long_lo[long_fill] = s;
        long_hi[long_fill] = e;
        long_tag[long_fill] = it.gene_tag;
        long_fill++;
      end else if (main_fill < MAIN_DEPTH) begin
        main_lo[main_fill] = s;
        main_hi[main_fill] = e;
        main_tag[main_fill] = it.gene_tag;
        main_fill++;
      end else begin
        full = 1'b1;
      end
      if (it.final_insert) build_index();
      add_result('0, 1'b0, 1'b1, 1'b0, '0, full);
      return;
    end
    if (!is_built) build_index();
    if (e <= s) begin
      add_result('0, 1'b0, 1'b1, 1'b0, '0, 1'b0);
      return;
    end
    trunc = 1'b0;
    scanned = 0;
    for (int i = 0; i < long_fill; i++) begin
      scanned++;
      if (long_lo[i] < e && long_hi[i] > s) begin
        if (found.size() < MAX_HITS) found.insert(found.size(), long_tag[i]);
        else trunc = 1'b1;
      end
    end
    lo = 0;
    hi = main_fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (main_lo[mid] < e) lo = mid + 1;
      else hi = mid;
    end
    for (int i = lo; i > 0; i--) begin
      k = i - 1;
      scanned++;
      if (main_reach[k] <= s) break;
      if (main_hi[k] > s) begin
        if (found.size() < MAX_HITS) found.insert(found.size(), main_tag[k]);
        else trunc = 1'b1;
      end
    end
    if (found.size() == 0) begin
      add_result('0, 1'b0, 1'b1, trunc, scanned[SCAN_W-1:0], 1'b0);
      return;
    end
    foreach (found[i]) begin
      if (i == found.size() - 1) add_result(found[i], 1'b1, 1'b1, trunc, scanned[SCAN_W-1:0], 1'b0);
      else add_result(found[i], 1'b1, 1'b0, 1'b0, '0, 1'b0);
    end
  endtask

  // Sends one item, honoring the burst and gap pattern of the sender. The
  // expectation is formed at the edge where the handshake completes.
  task automatic send_item(logic op, logic [31:0] s, logic [31:0] e,
                           logic [GENE_W-1:0] g, logic fin);
    in_item_t it;
    int gap;
    it.operation = op;
    it.range_start = s;
    it.range_end = e;
    it.gene_tag = g;
    it.final_insert = fin;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_overlaps(it);
    items_sent++;
    if (op == OP_QUERY) queries_sent++;
    // Valid stays high into the next item; it drops only when a gap starts or the sender goes idle.
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    // A build may still run after its insert has answered; wait until the
    // block is back in its idle state.
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_long_len(logic [31:0] v);
    go_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    shadow_long_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker: compares every accepted item with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      hits_seen++;
      if (pending_hits.size() == 0) begin
        $error("unexpected result item gene=%0h", out_item.hit_gene);
        failures++;
      end else begin
        want = pending_hits.pop_front();
        if (out_item.hit_gene !== want.hit_gene) begin
          $error("hit_gene expected %0h got %0h", want.hit_gene, out_item.hit_gene);
          failures++;
        end
        if (out_item.hit_valid !== want.hit_valid) begin
          $error("hit_valid expected %0b got %0b", want.hit_valid, out_item.hit_valid);
          failures++;
        end
        if (out_item.run_last !== want.run_last) begin
          $error("run_last expected %0b got %0b", want.run_last, out_item.run_last);
          failures++;
        end
        if (out_item.truncated !== want.truncated) begin
          $error("truncated expected %0b got %0b", want.truncated, out_item.truncated);
          failures++;
        end
        if (out_item.scanned_count !== want.scanned_count) begin
          $error("scanned_count expected %0d got %0d", want.scanned_count,
                 out_item.scanned_count);
          failures++;
        end
        if (out_item.store_full !== want.store_full) begin
          $error("store_full expected %0b got %0b", want.store_full, out_item.store_full);
          failures++;
        end
      end
    end
  end

  // Receiver stalls on its own pattern: quiet stretches, then random stalls.
  always @(posedge clk) begin
    if ((cycle_count / 3000) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 2) == 0);
  end

  // Watchdog. The slowest correct run is dominated by table builds and
  // stalled query streams; this limit covers that many times over.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Directed: field extremes, both operations and corner cases.
  task automatic test_directed();
    send_item(OP_QUERY, 32'd10, 32'd20, 20'd0, 1'b0);        // query before build, empty
    send_item(OP_INSERT, 32'd100, 32'd200, 20'hFFFFF, 1'b0);
    send_item(OP_INSERT, 32'd150, 32'd120, 20'h00001, 1'b0); // reversed interval
    send_item(OP_INSERT, 32'd0, 32'hFFFF_FFFF, 20'h5A5A5, 1'b0); // long one
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hA5A5A, 1'b0);
    send_item(OP_INSERT, 32'd100, 32'd150, 20'h12345, 1'b0);
    send_item(OP_INSERT, 32'd100, 32'd150, 20'h54321, 1'b1); // tie, then build
    send_item(OP_QUERY, 32'd120, 32'd130, 20'hFFFFF, 1'b1);
    send_item(OP_QUERY, 32'd130, 32'd130, 20'd0, 1'b0);      // empty range
    send_item(OP_QUERY, 32'd300, 32'd100, 20'd0, 1'b0);      // reversed range
    send_item(OP_QUERY, 32'd200, 32'd300, 20'd0, 1'b0);      // no match in main
    send_item(OP_QUERY, 32'd0, 32'hFFFF_FFFF, 20'd0, 1'b0);
    send_item(OP_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 20'd0, 1'b0);
  endtask

  // Over MAX_HITS matches, and a long list that overflows into main.
  task automatic test_truncation();
    write_long_len(32'd1000);
    for (int i = 0; i < LONG_DEPTH + 4; i++)
      send_item(OP_INSERT, i * 10, i * 10 + 5000, GENE_W'($urandom), 1'b0);
    for (int i = 0; i < 70; i++)
      send_item(OP_INSERT, $urandom_range(0, 500), $urandom_range(600, 900),
                GENE_W'($urandom), i == 69);
    send_item(OP_QUERY, 32'd550, 32'd560, 20'd0, 1'b0);
    send_item(OP_QUERY, 32'd950, 32'd960, 20'd0, 1'b0);
  endtask

  // Thresholds of 1 and the largest value; with 1 every interval whose end is above its start counts as long.
  task automatic test_thresholds();
    write_long_len(32'd1);
    for (int i = 0; i < 20; i++)
      send_item(OP_INSERT, $urandom_range(0, 50), $urandom_range(0, 60),
                GENE_W'($urandom), 1'b0);
    send_item(OP_QUERY, 32'd10, 32'd40, 20'd0, 1'b0);
    write_long_len(32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'd0, 32'hFFFF_FFFF, 20'h0F0F0, 1'b0);
    send_item(OP_INSERT, 32'd5, 32'd9, 20'h0F0F1, 1'b1);
    send_item(OP_QUERY, 32'd6, 32'd7, 20'd0, 1'b0);
  endtask

  // Random tables of random sizes, each followed by a run of queries.
  task automatic test_random_tables();
    int n, span;
    logic [31:0] s, len;
    write_long_len($urandom_range(20, 400));
    while (items_sent < 270) begin
      if (items_sent > 190) go_idle();  // at least one full drain mid-stream
      n = $urandom_range(1, 24);
      span = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : 2000;
      for (int i = 0; i < n; i++) begin
        s = (span == 2000) ? $urandom_range(0, 2000) : $urandom;
        len = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 500);
        send_item(OP_INSERT, s, s + len, GENE_W'($urandom),
                  (i == n - 1) && $urandom_range(0, 3) != 0);
      end
      for (int i = 0; i < $urandom_range(2, 12); i++) begin
        s = (span == 2000) ? $urandom_range(0, 2100) : $urandom;
        len = ($urandom_range(0, 6) == 0) ? 32'd0 : $urandom_range(1, 300);
        send_item(OP_QUERY, s, s + len, GENE_W'($urandom), 1'($urandom));
      end
      if (items_sent > 230) break;
    end
  endtask

  initial begin
    shadow_long_len = LONG_LEN_RESET;
    main_fill = 0;
    long_fill = 0;
    is_built = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_truncation();
    test_thresholds();
    test_random_tables();
    go_idle();
    $display("Sent %0d items (%0d queries) over several thresholds and got %0d results.",
             items_sent, queries_sent, hits_seen);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
